// ===== design/pva_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg: shared definitions for the polyphonic voice allocator
// Widths, command and result codes, register indexes, the request record
// passed from the front end to the slot engine and the engine's result records.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int TAG_W     = 32;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int CMD_W     = 3;
	localparam int KIND_W    = 3;
	localparam int CNTDN_W   = 16;
	localparam int VIN_W     = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int RES_CAP   = 16;
	localparam int RES_IDX_W = $clog2(RES_CAP);
	localparam int RES_CNT_W = RES_IDX_W + 1;

	localparam logic [CMD_W-1:0] CMD_NOTE_ON     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OFF_BY_NOTE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_OFF_BY_TAG  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_KILL        = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_BY_TAG = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TICK        = 3'd5;

	localparam logic [KIND_W-1:0] KIND_STARTED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NO_FREE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_KILLED    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICES_IN_USE = 1'b1;

	localparam logic [VEL_W-1:0]   VEL_FULL      = 7'd127;
	localparam logic [CNTDN_W-1:0] RELEASE_RESET = 16'd1000;
	localparam logic [VIN_W-1:0]   VOICES_RESET  = 5'd16;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NOTE_W-1:0] note;
		logic [TAG_W-1:0]  tag;
		logic [VEL_W-1:0]  vel;
	} pva_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
	} pva_res_t;

	typedef struct packed {
		logic                 done;
		logic                 last;
		pva_res_t             res;
		logic [MAX_SLOTS-1:0] busy_mask;
		logic [MAX_SLOTS-1:0] freed_mask;
		logic [TAG_W-1:0]     oldest;
	} pva_out_t;

endpackage
`default_nettype wire

// ===== design/polyphonic_voice_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator: voice slot table for a polyphonic synthesiser
// Allocates, releases, kills, finds and ages voices in a sixteen-slot table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// queue ahead of the slot engine, and busy rises when the queue is full.
// Each request walks the sixteen slots one per cycle: it leaves the queue,
// walks the slots, closes and loads its first result, then presents the
// rest; a request gives between one and sixteen results. A queued request
// leaves the queue only after the last result of the one ahead of it.
// Results are presented on consecutive cycles, each
// for exactly one cycle with done high, and last marks the final result of a
// request; the receiver must take every result as it appears. Unknown
// command codes are accepted and dropped without a result. Registers are
// written through cfg_we, cfg_idx and cfg_data; the user must write them only
// while no request is pending, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pva_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [pva_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [pva_pkg::CMD_W-1:0]         cmd,
	input  wire logic [pva_pkg::NOTE_W-1:0]        note,
	input  wire logic [pva_pkg::TAG_W-1:0]         tag,
	input  wire logic [pva_pkg::VEL_W-1:0]         velocity,
	output logic                                   done,
	output logic [pva_pkg::KIND_W-1:0]             kind,
	output logic [pva_pkg::SLOT_W-1:0]             slot,
	output logic [pva_pkg::TAG_W-1:0]              voice_tag,
	output logic [pva_pkg::NOTE_W-1:0]             voice_note,
	output logic [pva_pkg::VEL_W-1:0]              voice_velocity,
	output logic [pva_pkg::MAX_SLOTS-1:0]          busy_mask,
	output logic [pva_pkg::MAX_SLOTS-1:0]          freed_mask,
	output logic [pva_pkg::TAG_W-1:0]              oldest_tag,
	output logic                                   last
);
	import pva_pkg::*;

	logic [CNTDN_W-1:0] release_ticks_q;
	logic [VIN_W-1:0]   voices_in_use_q;
	pva_req_t           in_req;
	pva_req_t           q_head;
	logic               q_valid;
	logic               q_pop;
	pva_out_t           eng_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_ticks_q <= RELEASE_RESET;
			voices_in_use_q <= VOICES_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RELEASE_TICKS: release_ticks_q <= cfg_data;
				REG_VOICES_IN_USE: voices_in_use_q <= cfg_data[VIN_W-1:0];
				default: begin
					release_ticks_q <= release_ticks_q;
				end
			endcase
		end
	end

	assign in_req = '{cmd: cmd, note: note, tag: tag, vel: velocity};

	pva_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (in_req),
		.busy    (busy),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	pva_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.release_ticks (release_ticks_q),
		.voices_in_use (voices_in_use_q),
		.out           (eng_out)
	);

	assign done           = eng_out.done;
	assign last           = eng_out.last;
	assign kind           = eng_out.res.kind;
	assign slot           = eng_out.res.slot;
	assign voice_tag      = eng_out.res.tag;
	assign voice_note     = eng_out.res.note;
	assign voice_velocity = eng_out.res.vel;
	assign busy_mask      = eng_out.busy_mask;
	assign freed_mask     = eng_out.freed_mask;
	assign oldest_tag     = eng_out.oldest;

	// A request's results arrive on consecutive cycles.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("result burst broken before its last result");

	// Only a tick sets the freed mask, and it gives a single result.
	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind != KIND_TICK_DONE) |-> (freed_mask == '0))
		else $error("freed mask set on a result other than a tick");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == KIND_TICK_DONE) |-> last)
		else $error("tick result is not the last of its request");

	// A failed request reports no voice and stands alone.
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((kind == KIND_NO_FREE) || (kind == KIND_NOT_FOUND))
		|-> (voice_tag == '0) && last)
		else $error("failed request reports a voice");

	// A started voice holds a non-zero tag and shows as busy.
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == KIND_STARTED) |-> (voice_tag != '0) && busy_mask[slot])
		else $error("started voice not marked busy");

endmodule
`default_nettype wire

// ===== design/pva_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_front: request intake
// Takes requests, drops unknown command codes and holds the rest in a
// two-entry queue until the slot engine is ready for them.
// ----------------------------------------------------------------------------
module pva_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire pva_pkg::pva_req_t       req,
	output logic                         busy,
	output logic                         q_valid,
	output pva_pkg::pva_req_t            q_head,
	input  wire logic                    q_pop
);
	import pva_pkg::*;

	pva_req_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       known;
	logic       push;
	logic       pop;

	assign known   = (req.cmd <= CMD_TICK);
	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy && known;
	assign q_valid = (count_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_head  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= req;
	end

endmodule
`default_nettype wire

// ===== design/pva_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pva_engine: slot table and command execution
// Walks the slot table one slot per cycle, applies the request to each slot,
// gathers the busy mask and the smallest sounding tag, then plays the buffered
// results out one per cycle.
// ----------------------------------------------------------------------------
module pva_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire pva_pkg::pva_req_t            q_head,
	output logic                              q_pop,
	input  wire logic [pva_pkg::CNTDN_W-1:0]  release_ticks,
	input  wire logic [pva_pkg::VIN_W-1:0]    voices_in_use,
	output pva_pkg::pva_out_t                 out
);
	import pva_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TAIL = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]           st_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [RES_IDX_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 hit_q;
	pva_req_t             req_q;
	logic [TAG_W-1:0]     next_tag_q;
	logic [MAX_SLOTS-1:0] busy_acc_q;
	logic [MAX_SLOTS-1:0] freed_acc_q;
	logic [TAG_W-1:0]     oldest_q;

	logic [MAX_SLOTS-1:0] slot_busy_q;
	logic [MAX_SLOTS-1:0] slot_rel_q;
	logic [TAG_W-1:0]     slot_tag_q  [MAX_SLOTS];
	logic [CNTDN_W-1:0]   slot_cntdn_q[MAX_SLOTS];
	logic [NOTE_W-1:0]    slot_note_q [MAX_SLOTS];
	pva_res_t             res_mem[RES_CAP];

	pva_out_t             out_q;

	logic                 cur_busy;
	logic                 cur_rel;
	logic [TAG_W-1:0]     cur_tag;
	logic [CNTDN_W-1:0]   cur_cntdn;
	logic [NOTE_W-1:0]    cur_note;
	logic                 tag_hit;
	logic                 act;
	logic                 report;
	logic                 nb;
	logic                 nr;
	logic [TAG_W-1:0]     nt;
	logic [CNTDN_W-1:0]   nc;
	logic                 freed_now;
	pva_res_t             res_new;
	pva_res_t             tail_res;
	logic [TAG_W-1:0]     tag_inc;
	logic                 is_last;

	assign cur_busy  = slot_busy_q[idx_q];
	assign cur_rel   = slot_rel_q[idx_q];
	assign cur_tag   = slot_tag_q[idx_q];
	assign cur_cntdn = slot_cntdn_q[idx_q];
	assign cur_note  = slot_note_q[idx_q];
	assign tag_hit   = (req_q.tag != '0) && cur_busy && !cur_rel && (cur_tag == req_q.tag);
	assign tag_inc   = next_tag_q + 1'b1;
	assign is_last   = ({1'b0, rd_q} + 1'b1) == cnt_q;
	assign q_pop     = (st_q == ST_IDLE);
	assign out       = out_q;

	always_comb begin
		act       = 1'b0;
		nb        = cur_busy;
		nr        = cur_rel;
		nt        = cur_tag;
		nc        = cur_cntdn;
		freed_now = 1'b0;
		res_new   = '0;
		res_new.slot = idx_q;
		case (req_q.cmd)
			CMD_NOTE_ON: begin
				act = !cur_busy && !hit_q && ({1'b0, idx_q} < voices_in_use);
				if (act) begin
					nb = 1'b1;
					nr = 1'b0;
					nc = '0;
					nt = next_tag_q;
				end
				res_new.kind = KIND_STARTED;
				res_new.tag  = next_tag_q;
				res_new.note = req_q.note;
				res_new.vel  = req_q.vel;
			end
			CMD_OFF_BY_NOTE, CMD_OFF_BY_TAG: begin
				if (req_q.cmd == CMD_OFF_BY_NOTE)
					act = cur_busy && (cur_note == req_q.note);
				else
					act = tag_hit;
				if (act) begin
					nr = 1'b1;
					nc = release_ticks;
					nt = '0;
				end
				res_new.kind = KIND_RELEASED;
				res_new.tag  = cur_tag;
				res_new.note = cur_note;
				res_new.vel  = req_q.vel;
			end
			CMD_KILL: begin
				act = tag_hit;
				if (act) begin
					nb = 1'b0;
					nr = 1'b0;
					nc = '0;
					nt = '0;
				end
				res_new.kind = KIND_KILLED;
				res_new.tag  = cur_tag;
				res_new.note = cur_note;
				res_new.vel  = VEL_FULL;
			end
			CMD_FIND_BY_TAG: begin
				act = tag_hit && !hit_q;
				res_new.kind = KIND_FOUND;
				res_new.tag  = cur_tag;
				res_new.note = cur_note;
			end
			CMD_TICK: begin
				if (cur_busy && cur_rel) begin
					if (cur_cntdn <= CNTDN_W'(1)) begin
						nb        = 1'b0;
						nr        = 1'b0;
						nc        = '0;
						nt        = '0;
						freed_now = 1'b1;
					end else begin
						nc = cur_cntdn - 1'b1;
					end
				end
			end
			default: begin
				act = 1'b0;
			end
		endcase
		report = act && (req_q.cmd != CMD_TICK) && (cnt_q < RES_CNT_W'(RES_CAP));

		tail_res = '0;
		if (req_q.cmd == CMD_TICK)
			tail_res.kind = KIND_TICK_DONE;
		else if (req_q.cmd == CMD_NOTE_ON)
			tail_res.kind = KIND_NO_FREE;
		else
			tail_res.kind = KIND_NOT_FOUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			idx_q       <= '0;
			rd_q        <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			next_tag_q  <= TAG_W'(1);
			slot_busy_q <= '0;
			slot_rel_q  <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_tag_q[i]   <= '0;
				slot_cntdn_q[i] <= '0;
			end
			out_q       <= '0;
		end else begin
			out_q.done <= (st_q == ST_EMIT);
			out_q.last <= (st_q == ST_EMIT) && is_last;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q  <= ST_SCAN;
						idx_q <= '0;
						cnt_q <= '0;
						hit_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					slot_busy_q[idx_q]  <= nb;
					slot_rel_q[idx_q]   <= nr;
					slot_tag_q[idx_q]   <= nt;
					slot_cntdn_q[idx_q] <= nc;
					if (act)
						hit_q <= 1'b1;
					if (report)
						cnt_q <= cnt_q + 1'b1;
					if (act && (req_q.cmd == CMD_NOTE_ON))
						next_tag_q <= (tag_inc == '0) ? TAG_W'(1) : tag_inc;
					idx_q <= idx_q + 1'b1;
					if (idx_q == SLOT_W'(MAX_SLOTS - 1))
						st_q <= ST_TAIL;
				end
				ST_TAIL: begin
					if ((req_q.cmd == CMD_TICK) || !hit_q)
						cnt_q <= RES_CNT_W'(1);
					rd_q <= '0;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					out_q.res        <= res_mem[rd_q];
					out_q.busy_mask  <= busy_acc_q;
					out_q.freed_mask <= freed_acc_q;
					out_q.oldest     <= oldest_q;
					rd_q             <= rd_q + 1'b1;
					if (is_last)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				req_q       <= q_head;
				busy_acc_q  <= '0;
				freed_acc_q <= '0;
				oldest_q    <= '0;
			end
			ST_SCAN: begin
				if (act && (req_q.cmd == CMD_NOTE_ON))
					slot_note_q[idx_q] <= req_q.note;
				if (report)
					res_mem[cnt_q[RES_IDX_W-1:0]] <= res_new;
				busy_acc_q[idx_q]  <= (req_q.cmd == CMD_TICK) ? cur_busy : nb;
				freed_acc_q[idx_q] <= freed_now;
				if (nb && !nr && (nt != '0) && ((oldest_q == '0) || (nt < oldest_q)))
					oldest_q <= nt;
			end
			ST_TAIL: begin
				if ((req_q.cmd == CMD_TICK) || !hit_q)
					res_mem[0] <= tail_res;
			end
			default: begin
				req_q <= req_q;
			end
		endcase
	end

endmodule
`default_nettype wire
